### design/dart_pkg.sv
// Shared types and constants for the divider and reloading timer core.
package dart_pkg;

    // Register indexes on the configuration port (byte address is 4 times the index).
    localparam logic [1:0] REG_DOUBLE_SPEED  = 2'd0;
    localparam logic [1:0] REG_TIMER_CONTROL = 2'd1;
    localparam logic [1:0] REG_TIMER_MODULO  = 2'd2;

    // Bit of timer_control that enables the timer.
    localparam int TIMER_ENABLE_BIT = 2;

    // Configuration register contents.
    typedef struct packed {
        logic       double_speed;
        logic [2:0] timer_control;
        logic [7:0] timer_modulo;
    } dart_cfg_t;

    // Status returned by the wrap fold unit.
    typedef struct packed {
        logic       done;
        logic       ovf;
        logic [7:0] value;
    } fold_stat_t;

    // Left shift applied to the doubled count for each clock-select code.
    function automatic logic [2:0] rate_shift(input logic [1:0] sel);
        logic [2:0] sh;
        begin
            case (sel)
                2'd0:    sh = 3'd0;
                2'd1:    sh = 3'd6;
                2'd2:    sh = 3'd4;
                default: sh = 3'd2;
            endcase
            return sh;
        end
    endfunction

endpackage

### design/dart_cfg.sv
// APB-style configuration registers of the divider and reloading timer core.
module dart_cfg
    import dart_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output dart_cfg_t   cfg
);

    logic       double_speed_reg;
    logic [2:0] timer_control_reg;
    logic [7:0] timer_modulo_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes; values are masked to the register width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            double_speed_reg  <= 1'b0;
            timer_control_reg <= 3'd0;
            timer_modulo_reg  <= 8'd0;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_DOUBLE_SPEED:  double_speed_reg  <= pwdata[0];
                REG_TIMER_CONTROL: timer_control_reg <= pwdata[2:0];
                REG_TIMER_MODULO:  timer_modulo_reg  <= pwdata[7:0];
                default:           ;
            endcase
        end
    end

    // Read data multiplexer.
    always_comb
    begin
        unique case (paddr[3:2])
            REG_DOUBLE_SPEED:  prdata = {31'd0, double_speed_reg};
            REG_TIMER_CONTROL: prdata = {29'd0, timer_control_reg};
            REG_TIMER_MODULO:  prdata = {24'd0, timer_modulo_reg};
            default:           prdata = 32'd0;
        endcase
    end

    assign cfg.double_speed  = double_speed_reg;
    assign cfg.timer_control = timer_control_reg;
    assign cfg.timer_modulo  = timer_modulo_reg;

endmodule

### design/dart_fold.sv
// Iterative wrap fold: reloads the timer counter from the modulo value once per cycle.
module dart_fold
    import dart_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [8:0] t_in,
    input  logic [7:0] modulo,
    output fold_stat_t stat
);

    logic [8:0] t_reg;
    logic [8:0] t_next;
    logic       ovf_reg;

    // One reload per cycle: t - 256 + modulo, with t - 256 being the low byte.
    always_comb
    begin
        t_next = t_reg;
        if (start)
        begin
            t_next = t_in;
        end
        else if (t_reg[8])
        begin
            t_next = {1'b0, t_reg[7:0]} + {1'b0, modulo};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg   <= 9'd0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            t_reg <= t_next;
            if (start)
            begin
                ovf_reg <= t_in[8];
            end
        end
    end

    assign stat.done  = ~t_reg[8];
    assign stat.ovf   = ovf_reg;
    assign stat.value = t_reg[7:0];

    // Every reload strictly lowers the count, so the fold always ends.
    a_fold_decreases: assert property (@(posedge clk) disable iff (!rst_n)
        (t_reg[8] && !start) |=> (t_reg < $past(t_reg)))
        else $error("fold step did not lower the counter");

    // The overflow flag only changes when a new fold starts.
    a_ovf_held: assert property (@(posedge clk) disable iff (!rst_n)
        !start |=> $stable(ovf_reg))
        else $error("overflow flag changed during a fold");

endmodule

### design/divider_and_reloading_timer_core.sv
// Top level of the divider and reloading timer core: sequencer, counters and result register.
//
//   Channel | Direction | Handshake           | Word
//   --------+-----------+---------------------+--------------------------------------------
//   in      | input     | in_valid / in_stall | cycles
//   out     | output    | out_valid/out_stall | divider_value, timer_value,
//           |           |                     | timer_overflow, scaled_cycles
//   cfg     | input     | psel/penable/pwrite | double_speed, timer_control, timer_modulo
//
// An input word passes from acceptance through S_CALC, S_FOLD and S_OUT to the result register;
// S_FOLD makes n (0 to 64) timer reloads, and the fold unit does one reload per cycle.
// The next word can be accepted once the sequencer is back in S_IDLE after the result is loaded.
// in_stall is high from acceptance until the result is loaded into the output register.
// A new word is taken while an earlier result still waits behind out_stall.
// Reset clears all counters, prescalers and configuration registers to zero.
module divider_and_reloading_timer_core
    import dart_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  cycles,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  divider_value,
    output logic [7:0]  timer_value,
    output logic        timer_overflow,
    output logic [8:0]  scaled_cycles
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_FOLD = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    dart_cfg_t  cfg;
    fold_stat_t fold_stat;

    logic [1:0]  state_reg;
    logic [1:0]  state_next;
    logic [8:0]  dbl_reg;
    logic [7:0]  divider_prescale_reg;
    logic [7:0]  divider_count_reg;
    logic [8:0]  timer_prescale_reg;
    logic [7:0]  timer_count_reg;
    logic        out_valid_reg;
    logic [7:0]  divider_value_reg;
    logic [7:0]  timer_value_reg;
    logic        timer_overflow_reg;
    logic [8:0]  scaled_cycles_reg;

    logic        in_accept;
    logic        out_free;
    logic        timer_en;
    logic [10:0] div_acc;
    logic [15:0] tim_add;
    logic [15:0] tim_acc;
    logic [8:0]  fold_in;
    logic        fold_start;

    dart_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dart_fold u_fold (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (fold_start),
        .t_in   (fold_in),
        .modulo (cfg.timer_modulo),
        .stat   (fold_stat)
    );

    assign in_stall   = (state_reg != S_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign timer_en   = cfg.timer_control[TIMER_ENABLE_BIT];
    assign fold_start = (state_reg == S_CALC);

    // Prescaler sums: divider adds twice the doubled count, timer adds the shifted count.
    assign div_acc = {3'd0, divider_prescale_reg} + {1'b0, dbl_reg, 1'b0};
    assign tim_add = {7'd0, dbl_reg} << rate_shift(cfg.timer_control[1:0]);
    assign tim_acc = {7'd0, timer_prescale_reg} + tim_add;

    // Counter plus carries; a disabled timer passes its count through unchanged.
    always_comb
    begin
        if (timer_en)
        begin
            fold_in = {1'b0, timer_count_reg} + {2'b00, tim_acc[15:9]};
        end
        else
        begin
            fold_in = {1'b0, timer_count_reg};
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                state_next = S_FOLD;
            end
            S_FOLD:
            begin
                if (fold_stat.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            divider_prescale_reg <= 8'd0;
            divider_count_reg    <= 8'd0;
            timer_prescale_reg   <= 9'd0;
            timer_count_reg      <= 8'd0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Prescaler and divider update.
            if (state_reg == S_CALC)
            begin
                divider_prescale_reg <= div_acc[7:0];
                divider_count_reg    <= divider_count_reg + {5'd0, div_acc[10:8]};
                if (timer_en)
                begin
                    timer_prescale_reg <= tim_acc[8:0];
                end
            end

            // Result hand-off to the output register.
            if (state_reg == S_OUT && out_free)
            begin
                timer_count_reg <= fold_stat.value;
                out_valid_reg   <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            dbl_reg <= {cycles, 1'b0};
        end
        if (state_reg == S_OUT && out_free)
        begin
            divider_value_reg  <= divider_count_reg;
            timer_value_reg    <= fold_stat.value;
            timer_overflow_reg <= fold_stat.ovf;
            scaled_cycles_reg  <= dbl_reg >> cfg.double_speed;
        end
    end

    assign out_valid      = out_valid_reg;
    assign divider_value  = divider_value_reg;
    assign timer_value    = timer_value_reg;
    assign timer_overflow = timer_overflow_reg;
    assign scaled_cycles  = scaled_cycles_reg;

    // An accepted word always moves on to the prescaler update.
    a_accept_calc: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == S_CALC))
        else $error("accepted word did not reach the update step");

    // The result is only handed off once the fold has finished.
    a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> fold_stat.done)
        else $error("result taken before the fold finished");

    // A new result appears only from the hand-off step.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_OUT))
        else $error("result valid raised outside the hand-off step");

endmodule
